/* rtl/core/tbpf_pkg.sv */
// Shared constants and types for the tiled background pixel fetch block.
package tbpf_pkg;

    localparam int VIDEO_MEMORY_BYTES = 131072;
    localparam int ADDR_W             = 17;
    localparam int BANK_DEPTH         = VIDEO_MEMORY_BYTES / 2;
    localparam int BANK_AW            = $clog2(BANK_DEPTH);

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 9;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAP_BASE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TILE_BASE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EIGHT_BIT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HSCROLL    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_VSCROLL    = 3'd5;

    // Request kinds carried in s_tuser
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_RENDER = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TILE,
        ST_PIX
    } fetch_state_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } vram_wr_t;

endpackage

/* rtl/core/tbpf_vram.sv */
// Video memory split into even and odd byte banks, one registered read row.
module tbpf_vram
(
    input  logic                      clk,
    input  tbpf_pkg::vram_wr_t        wr,
    input  logic                      rd_en,
    input  logic [tbpf_pkg::BANK_AW-1:0] rd_row,
    output logic [7:0]                rd_even,
    output logic [7:0]                rd_odd
);
    import tbpf_pkg::*;

    logic [7:0] bank_even [BANK_DEPTH];
    logic [7:0] bank_odd  [BANK_DEPTH];
    logic       wr_ok;

    assign wr_ok = wr.en && ({15'd0, wr.addr} < VIDEO_MEMORY_BYTES);

    always_ff @(posedge clk)
    begin
        if (wr_ok && !wr.addr[0])
        begin
            bank_even[wr.addr[BANK_AW:1]] <= wr.data;
        end
        if (rd_en)
        begin
            rd_even <= bank_even[rd_row];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_ok && wr.addr[0])
        begin
            bank_odd[wr.addr[BANK_AW:1]] <= wr.data;
        end
        if (rd_en)
        begin
            rd_odd <= bank_odd[rd_row];
        end
    end

endmodule

/* rtl/core/tiled_background_pixel_fetch.sv */
// Tiled background pixel fetch: video memory, map and tile lookup per pixel.
//
//  channel | direction | handshake           | payload
//  s_*     | in        | s_tvalid / s_tready | s_tuser command, s_tdata write or render request
//  m_*     | out       | m_tvalid / m_tready | m_tdata palette index and column
//  cfg_*   | in        | cfg_valid/cfg_ready | cfg_index register, cfg_data value
//
// A write request is stored as it is accepted; a render request reads the
// map entry (both byte banks at once) and then the tile byte, both
// through the one registered read row of the video memory.
// The result sits in an output register; the next request is taken while
// it waits. A full output register stalls the render at its last step.
// Reset clears the configuration registers and control; memory contents are not cleared.
module tiled_background_pixel_fetch
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [16:0] mem_address, [24:17] mem_data, [32:25] pixel_column,
    // [40:33] pixel_row, [47:41] zero
    input  logic [tbpf_pkg::S_TDATA_W-1:0]     s_tdata,
    // [0] command
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [7:0] palette_index, [15:8] column_echo
    output logic [tbpf_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tbpf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tbpf_pkg::CFG_DAT_W-1:0]     cfg_data
);
    import tbpf_pkg::*;

    logic [4:0] map_base_reg;
    logic [1:0] tile_base_reg;
    logic [1:0] screen_size_reg;
    logic       eight_bit_reg;
    logic [8:0] hscroll_reg;
    logic [8:0] vscroll_reg;

    fetch_state_t state_reg, state_next;

    logic [2:0] xf_reg, yf_reg;
    logic [7:0] col_reg;
    logic       sel_reg;
    logic       m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg;

    logic       accept, render_acc, out_free, out_load, map_load, rd_en;
    logic [BANK_AW-1:0] rd_row;
    vram_wr_t   wr;
    logic [7:0] rd_even, rd_odd;

    logic [7:0]  in_col, in_row;
    logic [8:0]  x_sum, y_sum, x_pos, y_pos;
    logic [ADDR_W-1:0] map_addr, tile_addr;
    logic [15:0] entry;
    logic [7:0]  tile_byte, pixel;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_base_reg    <= '0;
            tile_base_reg   <= '0;
            screen_size_reg <= '0;
            eight_bit_reg   <= 1'b0;
            hscroll_reg     <= '0;
            vscroll_reg     <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_MAP_BASE:  map_base_reg    <= cfg_data[4:0];
                REG_TILE_BASE: tile_base_reg   <= cfg_data[1:0];
                REG_SCREEN:    screen_size_reg <= cfg_data[1:0];
                REG_EIGHT_BIT: eight_bit_reg   <= cfg_data[0];
                REG_HSCROLL:   hscroll_reg     <= cfg_data;
                REG_VSCROLL:   vscroll_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // Map address from the incoming request
    assign in_col = s_tdata[32:25];
    assign in_row = s_tdata[40:33];
    assign x_sum  = {1'b0, in_col} + hscroll_reg;
    assign y_sum  = {1'b0, in_row} + vscroll_reg;
    assign x_pos  = screen_size_reg[0] ? x_sum : {1'b0, x_sum[7:0]};
    assign y_pos  = screen_size_reg[1] ? y_sum : {1'b0, y_sum[7:0]};

    always_comb
    begin
        map_addr = {1'b0, map_base_reg, 11'd0} + {10'd0, x_pos[8:3], 1'b0};
        if (screen_size_reg[0])
        begin
            map_addr = map_addr + {4'd0, y_pos[8:3], 7'd0};
        end
        else
        begin
            map_addr = map_addr + {5'd0, y_pos[8:3], 6'd0};
        end
    end

    // Tile byte address from the map entry just read
    assign entry = {rd_odd, rd_even};

    always_comb
    begin
        if (eight_bit_reg)
        begin
            tile_addr = {1'b0, tile_base_reg, 14'd0} + {2'd0, entry[8:0], 6'd0}
                      + {11'd0, yf_reg, 3'd0} + {14'd0, xf_reg};
        end
        else
        begin
            tile_addr = {1'b0, tile_base_reg, 14'd0} + {2'd0, entry[9:0], 5'd0}
                      + {12'd0, yf_reg, 2'd0} + {15'd0, xf_reg[2:1]};
        end
    end

    assign tile_byte = sel_reg ? rd_odd : rd_even;
    assign pixel = eight_bit_reg ? tile_byte
                 : (xf_reg[0] ? {4'd0, tile_byte[7:4]} : {4'd0, tile_byte[3:0]});

    assign accept     = s_tvalid && s_tready;
    assign render_acc = accept && (s_tuser == CMD_RENDER);
    assign out_free   = !m_valid_reg || m_tready;

    assign wr.en   = accept && (s_tuser == CMD_WRITE);
    assign wr.addr = s_tdata[16:0];
    assign wr.data = s_tdata[24:17];

    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        rd_en      = 1'b0;
        rd_row     = map_addr[BANK_AW:1];
        out_load   = 1'b0;
        map_load   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (render_acc)
                begin
                    rd_en      = 1'b1;
                    map_load   = 1'b1;
                    state_next = ST_TILE;
                end
            end
            ST_TILE:
            begin
                rd_en      = 1'b1;
                rd_row     = tile_addr[BANK_AW:1];
                state_next = ST_PIX;
            end
            ST_PIX:
            begin
                s_tready = out_free;
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                    if (render_acc)
                    begin
                        rd_en      = 1'b1;
                        map_load   = 1'b1;
                        state_next = ST_TILE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (out_load)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (map_load)
        begin
            xf_reg  <= x_pos[2:0];
            yf_reg  <= y_pos[2:0];
            col_reg <= in_col;
        end
        if (state_reg == ST_TILE)
        begin
            sel_reg <= tile_addr[0];
        end
        if (out_load)
        begin
            m_data_reg <= {col_reg, pixel};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    tbpf_vram u_vram
    (
        .clk     (clk),
        .wr      (wr),
        .rd_en   (rd_en),
        .rd_row  (rd_row),
        .rd_even (rd_even),
        .rd_odd  (rd_odd)
    );

endmodule

/* tb/tiled_background_pixel_fetch_tb.sv */
// Self-checking testbench for the tiled background pixel fetch block.
`timescale 1ns / 1ps

module tiled_background_pixel_fetch_tb;
    import tbpf_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int IDLE_MARGIN     = 6;
    localparam int DRAIN_CYCLES    = 10;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int PHASE_REQUESTS  = 65;
    localparam int PHASES          = 6;

    // indexes past the register list; writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

    typedef struct {
        logic [7:0] palette;
        logic [7:0] column;
    } pixel_result_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 s_tuser   = CMD_WRITE;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data  = '0;

    tiled_background_pixel_fetch dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // shadow of the block: registers and video memory
    logic [4:0] reg_map_base  = '0;
    logic [1:0] reg_tile_base = '0;
    logic [1:0] reg_screen    = '0;
    logic       reg_eight_bit = 1'b0;
    logic [8:0] reg_hscroll   = '0;
    logic [8:0] reg_vscroll   = '0;
    bit [7:0]   vram_shadow  [VIDEO_MEMORY_BYTES];
    bit         vram_written [VIDEO_MEMORY_BYTES];

    pixel_result_t expected_pixels[$];

    int   cycle_count    = 0;
    int   error_count    = 0;
    int   results_taken  = 0;
    int   requests_sent  = 0;
    int   writes_sent    = 0;
    int   renders_sent   = 0;
    int   register_writes = 0;
    int   settings_used  = 0;
    bit   burst_mode     = 1'b0;
    bit   hold_off_active = 1'b0;
    event start_hold_off;

    int         last_map_addr = 0;
    int         last_tile_addr = 0;
    logic [7:0] last_col = '0;
    logic [7:0] last_row = '0;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d results still pending", $time, expected_pixels.size());
            $display("Verification failed");
            $finish;
        end
    end

    // Map entry address, tile byte address and nibble select for one pixel
    function automatic void locate_pixel(input logic [7:0] col, input logic [7:0] row,
                                         output int map_addr, output int tile_addr,
                                         output bit odd_column);
        int x;
        int y;
        int entry;
        x = (int'(col) + int'(reg_hscroll)) & (reg_screen[0] ? 'h1ff : 'hff);
        y = (int'(row) + int'(reg_vscroll)) & (reg_screen[1] ? 'h1ff : 'hff);
        map_addr = ((int'(reg_map_base) << 11) + ((y >> 3) << (reg_screen[0] ? 7 : 6))
                    + ((x >> 3) << 1)) % VIDEO_MEMORY_BYTES;
        entry = int'(vram_shadow[map_addr])
              | (int'(vram_shadow[(map_addr + 1) % VIDEO_MEMORY_BYTES]) << 8);
        if (reg_eight_bit)
            tile_addr = (int'(reg_tile_base) << 14) + ((entry & 'h1ff) << 6)
                      + ((y & 7) << 3) + (x & 7);
        else
            tile_addr = (int'(reg_tile_base) << 14) + ((entry & 'h3ff) << 5)
                      + ((y & 7) << 2) + ((x & 7) >> 1);
        tile_addr = tile_addr % VIDEO_MEMORY_BYTES;
        odd_column = x[0];
    endfunction

    // One request on the input stream; the shadow is updated once it is accepted
    task automatic push_request(input logic cmd, input logic [16:0] addr,
                                input logic [7:0] data, input logic [7:0] col,
                                input logic [7:0] row);
        int         gap;
        int         map_addr;
        int         tile_addr;
        bit         odd;
        logic [7:0] pix;
        gap = burst_mode ? 0 : $urandom_range(0, 8);
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {7'd0, row, col, data, addr};
        do @(posedge clk); while (!s_tready);
        requests_sent++;
        if (cmd == CMD_WRITE)
        begin
            vram_shadow[addr]  = data;
            vram_written[addr] = 1'b1;
            writes_sent++;
        end
        else
        begin
            locate_pixel(col, row, map_addr, tile_addr, odd);
            pix = vram_shadow[tile_addr];
            if (!reg_eight_bit)
                pix = odd ? {4'h0, pix[7:4]} : {4'h0, pix[3:0]};
            expected_pixels.push_back('{palette: pix, column: col});
            renders_sent++;
        end
    endtask

    task automatic write_byte(input int addr, input logic [7:0] data);
        push_request(CMD_WRITE, addr[16:0], data,
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    endtask

    // Renders a pixel after filling in any map or tile byte it would read unwritten
    task automatic render_pixel(input logic [7:0] col, input logic [7:0] row);
        int map_addr;
        int tile_addr;
        bit odd;
        locate_pixel(col, row, map_addr, tile_addr, odd);
        if (!vram_written[map_addr])
            write_byte(map_addr, 8'($urandom_range(0, 255)));
        if (!vram_written[map_addr + 1])
            write_byte(map_addr + 1, 8'($urandom_range(0, 255)));
        locate_pixel(col, row, map_addr, tile_addr, odd);
        if (!vram_written[tile_addr])
            write_byte(tile_addr, 8'($urandom_range(0, 255)));
        push_request(CMD_RENDER, 17'($urandom_range(0, VIDEO_MEMORY_BYTES - 1)),
                     8'($urandom_range(0, 255)), col, row);
        last_map_addr  = map_addr;
        last_tile_addr = tile_addr;
        last_col       = col;
        last_row       = row;
    endtask

    // Drops the request, waits for every result and for a trailing write to finish
    task automatic wait_until_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge clk);
        repeat (IDLE_MARGIN) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DAT_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_MAP_BASE:  reg_map_base  = value[4:0];
            REG_TILE_BASE: reg_tile_base = value[1:0];
            REG_SCREEN:    reg_screen    = value[1:0];
            REG_EIGHT_BIT: reg_eight_bit = value[0];
            REG_HSCROLL:   reg_hscroll   = value;
            REG_VSCROLL:   reg_vscroll   = value;
            default: ;
        endcase
        register_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic program_registers(input logic [8:0] map_base, input logic [8:0] tile_base,
                                     input logic [8:0] screen, input logic [8:0] eight_bit,
                                     input logic [8:0] hscroll, input logic [8:0] vscroll);
        wait_until_idle();
        write_register(REG_MAP_BASE, map_base);
        write_register(REG_TILE_BASE, tile_base);
        write_register(REG_SCREEN, screen);
        write_register(REG_EIGHT_BIT, eight_bit);
        write_register(REG_HSCROLL, hscroll);
        write_register(REG_VSCROLL, vscroll);
        settings_used++;
    endtask

    // ---------------- result side ----------------

    always @(posedge clk)
    begin : result_checker
        pixel_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_taken++;
            if (expected_pixels.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got palette %0d column %0d",
                         $time, m_tdata[7:0], m_tdata[15:8]);
                error_count++;
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (m_tdata[7:0] !== want.palette)
                begin
                    $display("%0t: palette_index mismatch, expected %0d, got %0d",
                             $time, want.palette, m_tdata[7:0]);
                    error_count++;
                end
                if (m_tdata[15:8] !== want.column)
                begin
                    $display("%0t: column_echo mismatch, expected %0d, got %0d",
                             $time, want.column, m_tdata[15:8]);
                    error_count++;
                end
            end
        end
    end

    initial
    begin : result_acceptor
        int gap;
        int seen;
        gap  = 0;
        seen = 0;
        forever
        begin
            @(negedge clk);
            // new wait drawn after each accepted result
            if (results_taken != seen)
            begin
                seen = results_taken;
                gap  = burst_mode ? 0 : $urandom_range(0, 8);
            end
            if (hold_off_active)
                m_tready <= 1'b0;
            else if (gap > 0)
            begin
                m_tready <= 1'b0;
                gap--;
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin : hold_off_counter
        forever
        begin
            @(start_hold_off);
            hold_off_active = 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clk);
            hold_off_active = 1'b0;
        end
    end

    // ---------------- tests ----------------

    // registers at reset values, address and pixel extremes, both nibbles
    task automatic test_default_registers();
        write_byte(0, 8'h00);
        write_byte(VIDEO_MEMORY_BYTES - 1, 8'h00);
        write_byte(VIDEO_MEMORY_BYTES - 1, 8'hff);
        render_pixel(8'd0, 8'd0);
        render_pixel(8'd1, 8'd0);
        render_pixel(8'd255, 8'd255);
    endtask

    // every register at its top value, 8-bit pixels, 512 x 512 map
    task automatic test_register_extremes();
        program_registers(9'h1ff, 9'h1ff, 9'h1ff, 9'h1ff, 9'h1ff, 9'h1ff);
        render_pixel(8'd0, 8'd0);
        render_pixel(8'd255, 8'd255);
    endtask

    task automatic test_ignored_registers();
        program_registers(9'd5, 9'd1, 9'd1, 9'd0, 9'd100, 9'd300);
        write_register(REG_UNUSED_LO, 9'($urandom_range(0, 511)));
        write_register(REG_UNUSED_HI, 9'($urandom_range(0, 511)));
        render_pixel(8'd239, 8'd159);
        render_pixel(8'd16, 8'd200);
    endtask

    task automatic test_random_traffic();
        int target;
        int pick;
        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase == 0)
                program_registers('0, '0, '0, '0, '0, '0);
            else if (phase == 1)
                program_registers('1, '1, '1, '1, '1, '1);
            else
                program_registers(9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)),
                                  9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)),
                                  9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)));
            burst_mode = (phase == 3) || ($urandom_range(0, 3) == 0);
            target = requests_sent + PHASE_REQUESTS;
            while (requests_sent < target)
            begin
                pick = $urandom_range(0, 10);
                if (pick <= 5)
                    render_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                else if (pick <= 7)
                    // next column in the same row, which may share the map entry and tile byte
                    render_pixel(last_col + 8'd1, last_row);
                else if (pick == 8)
                begin
                    write_byte(last_tile_addr, 8'($urandom_range(0, 255)));
                    render_pixel(last_col, last_row);
                end
                else if (pick == 9)
                begin
                    // rewrite the low byte of the last map entry, which may point it at another tile
                    write_byte(last_map_addr, 8'($urandom_range(0, 255)));
                    render_pixel(last_col, last_row);
                end
                else
                    write_byte($urandom_range(0, VIDEO_MEMORY_BYTES - 1),
                               8'($urandom_range(0, 255)));
            end
        end
        burst_mode = 1'b0;
    endtask

    // output held off while renders keep coming, so the input must stall
    task automatic test_output_backpressure();
        program_registers(9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)),
                          9'($urandom_range(0, 511)), 9'd0,
                          9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)));
        burst_mode = 1'b1;
        -> start_hold_off;
        repeat (24) render_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        burst_mode = 1'b0;
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_default_registers();
        test_register_extremes();
        test_ignored_registers();
        test_random_traffic();
        test_output_backpressure();

        wait_until_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d memory writes and %0d pixel renders over %0d register settings",
                 writes_sent, renders_sent, settings_used);
        $display("%0d register writes, %0d results checked, %0d mismatches, one %0d-cycle hold-off",
                 register_writes, results_taken, error_count, HOLD_OFF_CYCLES);
        if (error_count == 0 && expected_pixels.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
